/* design/btfa_pkg.sv */
`default_nettype none

package btfa_pkg;

   // Build-time shape of the block.
   localparam int CHANNELS    = 4;
   localparam int SAMPLE_BITS = 24;

   // Fixed field widths of the channels.
   localparam int CH_W      = 2;
   localparam int RATIO_W   = 24;
   localparam int VALUE_W   = 35;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   // Register widths.
   localparam int SCALE_W = 10;
   localparam int COUNT_W = 8;
   localparam int LIMIT_W = 16;

   // Derived datapath widths.
   localparam int SCALED_W  = SAMPLE_BITS + SCALE_W;
   localparam int SUM_W     = SCALED_W + COUNT_W;
   localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int MUL_CNT_W = $clog2(SCALE_W);
   localparam int DIV_CNT_W = $clog2(SUM_W);

   localparam logic [MUL_CNT_W-1:0] MUL_LAST = MUL_CNT_W'(SCALE_W - 1);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(SUM_W - 1);
   localparam logic [CH_W:0]        CHANNELS_V = (CH_W + 1)'(CHANNELS);
   localparam logic [CHANNELS-1:0]  ALL_MASK = {CHANNELS{1'b1}};

   // Register reset values.
   localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(1000);
   localparam logic [COUNT_W-1:0] COUNT_RST = COUNT_W'(100);
   localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(1000);
   localparam logic [LIMIT_W-1:0] FRAMES_MAX = {LIMIT_W{1'b1}};

   // Register indexes on the configuration channel.
   localparam logic [CSR_IDX_W-1:0] REG_SCALE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_COUNT = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_LIMIT = CSR_IDX_W'(2);

   // Frame kinds.
   localparam logic KIND_OFFSETS = 1'b0;
   localparam logic KIND_MEASURE = 1'b1;

   typedef logic signed [SAMPLE_BITS-1:0] code_type;
   typedef logic signed [SCALED_W-1:0]    scaled_type;
   typedef logic signed [SCALED_W:0]      latest_type;
   typedef logic signed [SUM_W-1:0]       sum_type;
   typedef logic signed [VALUE_W-1:0]     value_type;
   typedef logic [COUNT_W-1:0]            count_type;

endpackage

`default_nettype wire

/* design/btfa_channels.sv */
`default_nettype none

interface btfa_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [btfa_pkg::CH_W-1:0]             channel;
   logic signed [btfa_pkg::RATIO_W-1:0]   ratio_code;

   modport source (output valid, output channel, output ratio_code, input ready);
   modport sink   (input valid, input channel, input ratio_code, output ready);
endinterface

interface btfa_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  frame_kind;
   logic signed [btfa_pkg::VALUE_W-1:0]   value_ch0;
   logic signed [btfa_pkg::VALUE_W-1:0]   value_ch1;
   logic signed [btfa_pkg::VALUE_W-1:0]   value_ch2;
   logic signed [btfa_pkg::VALUE_W-1:0]   value_ch3;

   modport source (output valid, output frame_kind, output value_ch0, output value_ch1,
                   output value_ch2, output value_ch3, input ready);
   modport sink   (input valid, input frame_kind, input value_ch0, input value_ch1,
                   input value_ch2, input value_ch3, output ready);
endinterface

interface btfa_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [btfa_pkg::CSR_IDX_W-1:0]        index;
   logic [btfa_pkg::CSR_DAT_W-1:0]        data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* design/btfa_serial_mul.sv */
`default_nettype none

// Shift-and-add multiplier: one bit of the scale factor per cycle, LSB first.
module btfa_serial_mul (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire btfa_pkg::code_type      code,
   input  wire logic [btfa_pkg::SCALE_W-1:0] scale,
   output      logic                    done,
   output      btfa_pkg::scaled_type    product
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [btfa_pkg::MUL_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [btfa_pkg::SCALE_W-1:0]      mplier_ff, mplier_in;
   btfa_pkg::scaled_type              mcand_ff, mcand_in;
   btfa_pkg::scaled_type              acc_ff, acc_in;

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      mplier_in = mplier_ff;
      mcand_in  = mcand_ff;
      acc_in    = acc_ff;
      if (start) begin
         busy_in   = 1'b1;
         cnt_in    = '0;
         mplier_in = scale;
         mcand_in  = btfa_pkg::scaled_type'(code);
         acc_in    = '0;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = mcand_ff <<< 1;
         mplier_in = mplier_ff >> 1;
         cnt_in    = cnt_ff + 1'b1;
         if (cnt_ff == btfa_pkg::MUL_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      mplier_ff <= mplier_in;
      mcand_ff  <= mcand_in;
      acc_ff    <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

`default_nettype wire

/* design/btfa_serial_div.sv */
`default_nettype none

// Restoring divider on the magnitude, one quotient bit per cycle, then a sign fix
// that truncates toward zero. The divisor must be nonzero.
module btfa_serial_div (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire btfa_pkg::sum_type       dividend,
   input  wire btfa_pkg::count_type     divisor,
   output      logic                    done,
   output      btfa_pkg::scaled_type    quotient
);

   logic                              busy_ff, busy_in;
   logic                              fin_ff, fin_in;
   logic                              done_ff, done_in;
   logic                              neg_ff, neg_in;
   logic [btfa_pkg::DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [btfa_pkg::SUM_W-1:0]        quo_ff, quo_in;
   btfa_pkg::count_type               rem_ff, rem_in;
   btfa_pkg::count_type               dsor_ff, dsor_in;
   btfa_pkg::scaled_type              result_ff, result_in;

   logic [btfa_pkg::COUNT_W:0]        trial;
   logic [btfa_pkg::COUNT_W:0]        diff;
   logic                              fits;
   btfa_pkg::sum_type                 neg_dividend;
   btfa_pkg::scaled_type              low_quo;

   assign trial        = {rem_ff, quo_ff[btfa_pkg::SUM_W-1]};
   assign diff         = trial - {1'b0, dsor_ff};
   assign fits         = (trial >= {1'b0, dsor_ff});
   assign neg_dividend = -dividend;
   assign low_quo      = btfa_pkg::scaled_type'(quo_ff[btfa_pkg::SCALED_W-1:0]);

   always_comb begin
      busy_in   = busy_ff;
      fin_in    = 1'b0;
      done_in   = 1'b0;
      neg_in    = neg_ff;
      cnt_in    = cnt_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dsor_in   = dsor_ff;
      result_in = result_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         neg_in  = dividend[btfa_pkg::SUM_W-1];
         quo_in  = dividend[btfa_pkg::SUM_W-1] ? neg_dividend : dividend;
         rem_in  = '0;
         dsor_in = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[btfa_pkg::COUNT_W-1:0] : trial[btfa_pkg::COUNT_W-1:0];
         quo_in = {quo_ff[btfa_pkg::SUM_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == btfa_pkg::DIV_LAST) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end else if (fin_ff) begin
         result_in = neg_ff ? -low_quo : low_quo;
         done_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff    <= neg_in;
      cnt_ff    <= cnt_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      dsor_ff   <= dsor_in;
      result_ff <= result_in;
   end

   assign done     = done_ff;
   assign quotient = result_ff;

endmodule

`default_nettype wire

/* design/bridge_tare_frame_aligner_unit.sv */
`default_nettype none

// Tare averaging and frame alignment for up to four load-cell bridge channels.
// Each word on req_ch carries a channel number and a signed converter code. The
// code is multiplied by scale_factor. While calibrating, each channel sums its
// first cal_count scaled samples; its tare offset is that sum divided by the
// number of samples summed, truncated toward zero. Samples for a channel that has
// finished are dropped until every channel is done, at which point one offsets
// word (frame_kind 0) goes out on rsp_ch. From then on every scaled sample minus
// its channel's offset is held, and each time all channels hold a fresh value one
// measurement word (frame_kind 1) goes out. After frame_limit measurement words
// the block drops all input until reset. Samples for a channel number at or above
// the channel count are dropped, and the value fields of absent channels read 0.
// All values are in units of one converter LSB times scale_factor. The block
// works on one sample at a time. A dropped sample is taken and discarded while
// idle. A kept sample passes through the bit-serial multiplier, which consumes
// one bit of scale_factor per cycle. The sample that completes a channel's
// calibration then also passes through the restoring divider, which produces
// one quotient bit per cycle over the 42-bit sum. A finished word waits in an
// output register, so the next sample is taken while rsp_ch is stalled; only a
// second word stalls the block until the first is taken. Configuration words on
// csr_ch are always accepted and take effect at once; index 3 is ignored. Write
// them only while no sample is in progress.
module bridge_tare_frame_aligner_unit (
   input wire logic     clock,
   input wire logic     reset,
   btfa_req_if.sink     req_ch,
   btfa_rsp_if.source   rsp_ch,
   btfa_csr_if.sink     csr_ch
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_MUL    = 5'b00010,
      ST_UPDATE = 5'b00100,
      ST_DIV    = 5'b01000,
      ST_EMIT   = 5'b10000
   } state_type;

   state_type                          state_ff, state_in;
   logic [btfa_pkg::CH_IDX_W-1:0]      ch_ff, ch_in;
   logic [btfa_pkg::SCALE_W-1:0]       scale_ff, scale_in;
   btfa_pkg::count_type                count_ff, count_in;
   logic [btfa_pkg::LIMIT_W-1:0]       limit_ff, limit_in;

   btfa_pkg::sum_type                  cal_sum_ff [btfa_pkg::CHANNELS];
   btfa_pkg::sum_type                  cal_sum_in [btfa_pkg::CHANNELS];
   btfa_pkg::count_type                cal_seen_ff [btfa_pkg::CHANNELS];
   btfa_pkg::count_type                cal_seen_in [btfa_pkg::CHANNELS];
   btfa_pkg::scaled_type               offset_ff [btfa_pkg::CHANNELS];
   btfa_pkg::scaled_type               offset_in [btfa_pkg::CHANNELS];
   btfa_pkg::latest_type               latest_ff [btfa_pkg::CHANNELS];
   btfa_pkg::latest_type               latest_in [btfa_pkg::CHANNELS];

   logic [btfa_pkg::CHANNELS-1:0]      fresh_ff, fresh_in;
   logic [btfa_pkg::CHANNELS-1:0]      cal_done_ff, cal_done_in;
   logic                               measuring_ff, measuring_in;
   logic [btfa_pkg::LIMIT_W-1:0]       frames_ff, frames_in;
   logic                               halted_ff, halted_in;
   logic                               div_start_ff, div_start_in;
   logic                               kind_ff, kind_in;

   logic                               out_valid_ff, out_valid_in;
   logic                               out_kind_ff, out_kind_in;
   btfa_pkg::value_type                out_value_ff [4];
   btfa_pkg::value_type                out_value_in [4];
   btfa_pkg::value_type                frame_value [4];

   logic                               accept;
   logic [btfa_pkg::CH_IDX_W-1:0]      req_idx;
   logic                               keep;
   logic                               mul_start;
   logic                               mul_done;
   btfa_pkg::scaled_type               product;
   logic                               div_done;
   btfa_pkg::scaled_type               quotient;
   btfa_pkg::count_type                seen_next;
   btfa_pkg::count_type                need;
   logic [btfa_pkg::CHANNELS-1:0]      ch_bit;
   logic                               out_load;

   assign accept  = req_ch.valid && req_ch.ready;
   assign req_idx = req_ch.channel[btfa_pkg::CH_IDX_W-1:0];

   // A sample is kept unless the block has halted, the channel is absent, or the
   // channel already has its offset while others are still calibrating.
   assign keep = !halted_ff
              && ({1'b0, req_ch.channel} < btfa_pkg::CHANNELS_V)
              && !(!measuring_ff && cal_done_ff[req_idx]);
   assign mul_start = accept && keep;

   assign ch_bit    = btfa_pkg::CHANNELS'(1) << ch_ff;
   assign seen_next = cal_seen_ff[ch_ff] + 1'b1;
   assign need      = (count_ff == '0) ? btfa_pkg::count_type'(1) : count_ff;
   assign out_load  = (state_ff == ST_EMIT) && (!out_valid_ff || rsp_ch.ready);

   btfa_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .code    (btfa_pkg::code_type'(req_ch.ratio_code[btfa_pkg::SAMPLE_BITS-1:0])),
      .scale   (scale_ff),
      .done    (mul_done),
      .product (product)
   );

   // The divider reads the sum and count after the update cycle has stored them.
   btfa_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (cal_sum_ff[ch_ff]),
      .divisor  (cal_seen_ff[ch_ff]),
      .done     (div_done),
      .quotient (quotient)
   );

   // Frame contents: offsets or tared values; absent channels read zero.
   for (genvar gi = 0; gi < 4; gi++) begin : g_frame
      if (gi < btfa_pkg::CHANNELS) begin : g_present
         assign frame_value[gi] = (kind_ff == btfa_pkg::KIND_MEASURE)
                                ? btfa_pkg::value_type'(latest_ff[gi])
                                : btfa_pkg::value_type'(offset_ff[gi]);
      end else begin : g_absent
         assign frame_value[gi] = '0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      scale_in     = scale_ff;
      count_in     = count_ff;
      limit_in     = limit_ff;
      cal_sum_in   = cal_sum_ff;
      cal_seen_in  = cal_seen_ff;
      offset_in    = offset_ff;
      latest_in    = latest_ff;
      fresh_in     = fresh_ff;
      cal_done_in  = cal_done_ff;
      measuring_in = measuring_ff;
      frames_in    = frames_ff;
      halted_in    = halted_ff;
      div_start_in = 1'b0;
      kind_in      = kind_ff;
      out_kind_in  = out_kind_ff;
      out_value_in = out_value_ff;
      out_valid_in = out_valid_ff;

      if (out_valid_ff && rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end

      if (csr_ch.valid && csr_ch.ready) begin
         case (csr_ch.index)
            btfa_pkg::REG_SCALE: scale_in = csr_ch.data[btfa_pkg::SCALE_W-1:0];
            btfa_pkg::REG_COUNT: count_in = csr_ch.data[btfa_pkg::COUNT_W-1:0];
            btfa_pkg::REG_LIMIT: limit_in = csr_ch.data[btfa_pkg::LIMIT_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (mul_start) begin
               ch_in    = req_idx;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (mul_done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            state_in = ST_IDLE;
            if (!measuring_ff) begin
               cal_sum_in[ch_ff]  = cal_sum_ff[ch_ff] + btfa_pkg::sum_type'(product);
               cal_seen_in[ch_ff] = seen_next;
               if (seen_next >= need && seen_next != '0) begin
                  div_start_in = 1'b1;
                  state_in     = ST_DIV;
               end
            end else begin
               latest_in[ch_ff] = btfa_pkg::latest_type'(product)
                                - btfa_pkg::latest_type'(offset_ff[ch_ff]);
               if ((fresh_ff | ch_bit) == btfa_pkg::ALL_MASK) begin
                  fresh_in = '0;
                  kind_in  = btfa_pkg::KIND_MEASURE;
                  state_in = ST_EMIT;
               end else begin
                  fresh_in = fresh_ff | ch_bit;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               offset_in[ch_ff] = quotient;
               cal_done_in      = cal_done_ff | ch_bit;
               if ((cal_done_ff | ch_bit) == btfa_pkg::ALL_MASK) begin
                  measuring_in = 1'b1;
                  kind_in      = btfa_pkg::KIND_OFFSETS;
                  state_in     = ST_EMIT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_EMIT: begin
            if (out_load) begin
               out_valid_in = 1'b1;
               out_kind_in  = kind_ff;
               out_value_in = frame_value;
               state_in     = ST_IDLE;
               // The frame limit is checked after every measurement word.
               if (kind_ff == btfa_pkg::KIND_MEASURE) begin
                  frames_in = (frames_ff != btfa_pkg::FRAMES_MAX) ? frames_ff + 1'b1
                                                                  : frames_ff;
                  halted_in = halted_ff || (frames_in >= limit_ff);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scale_ff     <= btfa_pkg::SCALE_RST;
         count_ff     <= btfa_pkg::COUNT_RST;
         limit_ff     <= btfa_pkg::LIMIT_RST;
         cal_sum_ff   <= '{default: '0};
         cal_seen_ff  <= '{default: '0};
         offset_ff    <= '{default: '0};
         fresh_ff     <= '0;
         cal_done_ff  <= '0;
         measuring_ff <= 1'b0;
         frames_ff    <= '0;
         halted_ff    <= 1'b0;
         div_start_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scale_ff     <= scale_in;
         count_ff     <= count_in;
         limit_ff     <= limit_in;
         cal_sum_ff   <= cal_sum_in;
         cal_seen_ff  <= cal_seen_in;
         offset_ff    <= offset_in;
         fresh_ff     <= fresh_in;
         cal_done_ff  <= cal_done_in;
         measuring_ff <= measuring_in;
         frames_ff    <= frames_in;
         halted_ff    <= halted_in;
         div_start_ff <= div_start_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff        <= ch_in;
      latest_ff    <= latest_in;
      kind_ff      <= kind_in;
      out_kind_ff  <= out_kind_in;
      out_value_ff <= out_value_in;
   end

   assign req_ch.ready     = (state_ff == ST_IDLE);
   assign csr_ch.ready     = 1'b1;
   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.frame_kind = out_kind_ff;
   assign rsp_ch.value_ch0 = out_value_ff[0];
   assign rsp_ch.value_ch1 = out_value_ff[1];
   assign rsp_ch.value_ch2 = out_value_ff[2];
   assign rsp_ch.value_ch3 = out_value_ff[3];

   // Any word on the output implies every channel has its offset.
   a_rsp_after_cal: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (cal_done_ff == btfa_pkg::ALL_MASK))
      else $error("result word before calibration finished");

   // The block can only halt out of the measurement phase.
   a_halt_in_measure: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> measuring_ff)
      else $error("halted while calibrating");

   // Fresh marks exist only in the measurement phase.
   a_fresh_cal: assert property (@(posedge clock) disable iff (reset)
      !measuring_ff |-> (fresh_ff == '0))
      else $error("fresh marks set during calibration");

   // A full set of fresh marks is always turned into a word before the next sample.
   a_fresh_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (fresh_ff != btfa_pkg::ALL_MASK))
      else $error("complete frame left pending");

endmodule

`default_nettype wire
